// ===== hdl/spc_pkg.sv =====
// ============================================================================
// spc_pkg: shared definitions for the stepper position controller
// Command codes, configuration register indexes, axis modes and the
// half-step coil table.
// ============================================================================
`default_nettype none

package spc_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_SET    = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_ZERO   = 3'd3,
    CMD_ADJUST = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_AXIS_MODE    = 3'd0,
    CFG_MODULO_STEPS = 3'd1,
    CFG_LOWER_LIMIT  = 3'd2,
    CFG_UPPER_LIMIT  = 3'd3,
    CFG_STEP_DELAY   = 3'd4,
    CFG_PSAVE_DELAY  = 3'd5,
    CFG_DIR_INVERT   = 3'd6
  } cfg_idx_t;

  // Axis modes; the unused code behaves as an unlimited axis.
  typedef enum logic [1:0] {
    AXIS_UNLIMITED = 2'd0,
    AXIS_MODULO    = 2'd1,
    AXIS_LIMITED   = 2'd2
  } axis_mode_t;

  localparam logic [1:0]  AXIS_MODE_RST    = 2'd0;
  localparam logic [15:0] MODULO_STEPS_RST = 16'd0;
  localparam logic [31:0] LOWER_LIMIT_RST  = 32'h8000_0001;
  localparam logic [31:0] UPPER_LIMIT_RST  = 32'h7fff_ffff;
  localparam logic [31:0] STEP_DELAY_RST   = 32'd1250;
  localparam logic [31:0] PSAVE_DELAY_RST  = 32'd0;

  localparam logic [3:0]  COILS_OFF = 4'h0;
  localparam logic [2:0]  PHASE_MAX = 3'h7;

  // Eight-phase half-step coil table, indexed by the phase.
  function automatic logic [3:0] coil_phase(input logic [2:0] pos_lsb, input logic rev);
    logic [2:0] ph;
    logic [3:0] pat;
    ph = rev ? (PHASE_MAX - pos_lsb) : pos_lsb;
    case (ph)
      3'd0:    pat = 4'h3;
      3'd1:    pat = 4'h2;
      3'd2:    pat = 4'h6;
      3'd3:    pat = 4'h4;
      3'd4:    pat = 4'hC;
      3'd5:    pat = 4'h8;
      3'd6:    pat = 4'h9;
      3'd7:    pat = 4'h1;
      default: pat = COILS_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stepper_position_controller.sv =====
// ============================================================================
// stepper_position_controller: half-step unipolar stepper position control
// Takes tick, target, zero and adjust commands, keeps position and target,
// and drives the four coils through the eight-phase half-step table.
// ============================================================================
// The block takes one command per clock cycle while the output side keeps
// up, and returns one result per command. A command is captured in an
// input register and resolved against the position, target, tick counter
// and coil state in a single pass of logic; the updated state registers
// themselves form the result register, so a result is presented once its
// command leaves the input register, which holds it while a result stalls.
// A tick steps the motor once more ticks than step_delay have passed;
// targets clamp to the limits on a limited axis, and a modulo axis takes
// the shorter way round and wraps the position.
`default_nettype none

module stepper_position_controller #(
  parameter int POSITION_WIDTH = 32,
  parameter int TIMER_WIDTH    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [2:0]  in_tuser,   // [2:0] cmd
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] coil_pattern, [35:4] position, [67:36] target, [68] at_target,
  // [69] stepped, [71:70] zero
  output logic [71:0]      out_tdata,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import spc_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int TW = TIMER_WIDTH;
  localparam int CW = (TW > 32) ? TW : 32;          // timer compare width
  localparam int DW = PW + 2;                       // exact step arithmetic
  localparam int SW = ((PW > 32) ? PW : 32) + 2;    // exact target arithmetic

  localparam logic [TW-1:0]        TIMER_MAX = '1;
  localparam logic [TW-1:0]        TIMER_ZERO = '0;
  localparam logic signed [DW-1:0] ONE_D = 1;
  localparam logic signed [DW-1:0] ZERO_D = 0;
  localparam logic signed [SW-1:0] ZERO_S = 0;
  localparam logic signed [PW-1:0] ZERO_P = 0;

  // Configuration registers.
  logic [1:0]         axis_mode_r;
  logic [15:0]        modulo_steps_r;
  logic signed [31:0] lower_limit_r;
  logic signed [31:0] upper_limit_r;
  logic [31:0]        step_delay_r;
  logic [31:0]        psave_delay_r;
  logic               dir_invert_r;

  // Input register.
  logic               in_valid_r;
  logic [2:0]         cmd_r;
  logic signed [31:0] value_r;

  // State registers, which also hold the result.
  logic signed [PW-1:0] position_r, position_nxt;
  logic signed [PW-1:0] target_r, target_nxt;
  logic [TW-1:0]        elapsed_r, elapsed_nxt;
  logic [3:0]           coils_r, coils_nxt;
  logic                 stepped_r, stepped_nxt;
  logic                 out_valid_r;

  logic advance;
  logic fire;

  // Configuration writes; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_mode_r    <= AXIS_MODE_RST;
      modulo_steps_r <= MODULO_STEPS_RST;
      lower_limit_r  <= LOWER_LIMIT_RST;
      upper_limit_r  <= UPPER_LIMIT_RST;
      step_delay_r   <= STEP_DELAY_RST;
      psave_delay_r  <= PSAVE_DELAY_RST;
      dir_invert_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AXIS_MODE:    axis_mode_r    <= cfg_data[1:0];
        CFG_MODULO_STEPS: modulo_steps_r <= cfg_data[15:0];
        CFG_LOWER_LIMIT:  lower_limit_r  <= cfg_data;
        CFG_UPPER_LIMIT:  upper_limit_r  <= cfg_data;
        CFG_STEP_DELAY:   step_delay_r   <= cfg_data;
        CFG_PSAVE_DELAY:  psave_delay_r  <= cfg_data;
        CFG_DIR_INVERT:   dir_invert_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result slot is free
  // or its result is being transferred out.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser;
      value_r <= in_tdata;
    end
  end

  // Shared decode of the axis configuration.
  logic                 is_mod;
  logic                 is_lim;
  logic signed [DW-1:0] mod_d, half_d;
  logic signed [SW-1:0] mod_s;

  assign is_mod = (axis_mode_r == AXIS_MODULO);
  assign is_lim = (axis_mode_r == AXIS_LIMITED);
  assign mod_d  = DW'($signed({1'b0, modulo_steps_r}));
  assign half_d = DW'($signed({2'b0, modulo_steps_r[15:1]}));
  assign mod_s  = SW'($signed({1'b0, modulo_steps_r}));

  // Tick timing: saturating increment, then compare against the delays.
  logic [TW-1:0] elapsed_inc;
  logic          step_due;
  logic          psave_due;

  assign elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign step_due    = CW'(elapsed_inc) > CW'(step_delay_r);
  assign psave_due   = (psave_delay_r != '0) && (CW'(elapsed_inc) > CW'(psave_delay_r));

  // Direction: exact difference, folded once onto the shorter way round.
  logic signed [DW-1:0] diff_d, dist_d, step_d, wrap_d;
  logic                 move;

  assign diff_d = DW'(target_r) - DW'(position_r);

  always_comb begin
    if (is_mod && (diff_d > half_d)) begin
      dist_d = diff_d - mod_d;
    end else if (is_mod && (diff_d < -half_d)) begin
      dist_d = diff_d + mod_d;
    end else begin
      dist_d = diff_d;
    end
  end

  assign move   = step_due && (dist_d != ZERO_D);
  assign step_d = dist_d[DW-1] ? DW'(position_r) - ONE_D : DW'(position_r) + ONE_D;

  // One step, wrapped once into the revolution on a modulo axis.
  always_comb begin
    if (is_mod && (step_d >= mod_d)) begin
      wrap_d = step_d - mod_d;
    end else if (is_mod && (step_d < ZERO_D)) begin
      wrap_d = step_d + mod_d;
    end else begin
      wrap_d = step_d;
    end
  end

  // New target: absolute or relative, clamped on a limited axis, wrapped
  // once on a modulo axis.
  logic signed [SW-1:0] val_s, raw_s, lo_s, hi_s, clamp_lo_s, clamp_s, trim_s;

  assign val_s      = SW'(value_r);
  assign raw_s      = (cmd_r == CMD_ADD) ? SW'(target_r) + val_s : val_s;
  assign lo_s       = SW'(lower_limit_r);
  assign hi_s       = SW'(upper_limit_r);
  assign clamp_lo_s = (raw_s < lo_s) ? lo_s : raw_s;

  always_comb begin
    if (is_lim) begin
      clamp_s = (clamp_lo_s > hi_s) ? hi_s : clamp_lo_s;
    end else begin
      clamp_s = raw_s;
    end
    if (is_mod && (clamp_s >= mod_s)) begin
      trim_s = clamp_s - mod_s;
    end else if (is_mod && (clamp_s < ZERO_S)) begin
      trim_s = clamp_s + mod_s;
    end else begin
      trim_s = clamp_s;
    end
  end

  // Adjust moves the position down by the value, wrapped to the width.
  logic signed [PW-1:0] adjust_p, stepped_p;

  assign adjust_p  = position_r - value_r[PW-1:0];
  assign stepped_p = wrap_d[PW-1:0];

  // Next state for the command in the input register.
  always_comb begin
    position_nxt = position_r;
    target_nxt   = target_r;
    elapsed_nxt  = elapsed_r;
    coils_nxt    = coils_r;
    stepped_nxt  = stepped_r;
    if (fire) begin
      stepped_nxt = 1'b0;
      case (cmd_r)
        CMD_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (move) begin
            position_nxt = stepped_p;
            elapsed_nxt  = TIMER_ZERO;
            coils_nxt    = coil_phase(stepped_p[2:0], dir_invert_r);
            stepped_nxt  = 1'b1;
          end else if (step_due && psave_due) begin
            coils_nxt = COILS_OFF;
          end
        end
        CMD_SET, CMD_ADD: begin
          target_nxt = trim_s[PW-1:0];
        end
        CMD_ZERO: begin
          position_nxt = ZERO_P;
          target_nxt   = ZERO_P;
        end
        CMD_ADJUST: begin
          position_nxt = adjust_p;
          coils_nxt    = coil_phase(adjust_p[2:0], dir_invert_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= ZERO_P;
      target_r    <= ZERO_P;
      elapsed_r   <= TIMER_ZERO;
      coils_r     <= COILS_OFF;
      stepped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      position_r  <= position_nxt;
      target_r    <= target_nxt;
      elapsed_r   <= elapsed_nxt;
      coils_r     <= coils_nxt;
      stepped_r   <= stepped_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result fields straight from the state registers.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, stepped_r, (position_r == target_r),
                       32'(target_r), 32'(position_r), coils_r};

`ifndef SYNTH
  // A step always restarts the tick counter.
  a_step_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && stepped_r) |-> (elapsed_r == TIMER_ZERO))
    else $error("step reported with a running tick counter");

  // A stalled result keeps the state that it reports.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(position_r) && $stable(target_r)
                                      && $stable(coils_r)))
    else $error("state changed while the result was stalled");

  // Only a tick can move the motor.
  a_step_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (cmd_r != CMD_TICK)) |=> !stepped_r)
    else $error("step reported for a command other than a tick");
`endif

endmodule

`default_nettype wire
